FILE: sv/rail_power_overload_guard_macros.svh
// Assertion macros for the rail power overload guard checks.
`ifndef RAIL_POWER_OVERLOAD_GUARD_MACROS_SVH
`define RAIL_POWER_OVERLOAD_GUARD_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RPOG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpog check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define RPOG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpog check failed");

`endif

FILE: sv/rpog_pkg.sv
// Shared types, constants and the persistence step for the overload guard.
package rpog_pkg;

  localparam int RAILS       = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam int MV_W    = 16;
  localparam int MA_W    = 16;
  localparam int VOLT_W  = 7;
  localparam int PROD_W  = 23;
  localparam int WATT_W  = 13;
  localparam int TOTAL_W = 14;
  localparam int MODE_W  = 8;
  localparam int CNT_W   = 8;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 3;

  // Reciprocals of 1000, exact over the full input ranges.
  localparam int VOLT_SHIFT = 26;
  localparam logic [16:0] VOLT_RECIP = 17'd67109;
  localparam int WATT_SHIFT = 33;
  localparam logic [23:0] WATT_RECIP = 24'd8589935;

  localparam logic [WATT_W-1:0] PEX_LIMIT_RST   = 13'd75;
  localparam logic [WATT_W-1:0] AUX4_LIMIT_RST  = 13'd150;
  localparam logic [WATT_W-1:0] AUX3_LIMIT_RST  = 13'd75;
  localparam logic [MODE_W-1:0] FULL_MODE_RST   = 8'd0;
  localparam logic [CNT_W-1:0]  PERSIST_RST     = 8'd10;
  localparam logic [CNT_W-1:0]  COUNT_RST       = 8'd1;

  localparam int RAIL_SLOT = 0;
  localparam int RAIL_AUX4 = 1;
  localparam int RAIL_AUX3 = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEX_LIMIT  = 3'd0,
    CFG_AUX4_LIMIT = 3'd1,
    CFG_AUX3_LIMIT = 3'd2,
    CFG_FULL_MODE  = 3'd3,
    CFG_PERSIST    = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [WATT_W-1:0] pex_limit;
    logic [WATT_W-1:0] aux4_limit;
    logic [WATT_W-1:0] aux3_limit;
    logic [MODE_W-1:0] full_mode;
  } limits_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               failed;
    logic               pex_over;
    logic               aux_over;
    logic               full;
  } class_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             tripped;
    logic             fire;
    logic             clear;
  } path_t;

  function automatic path_t path_step(input logic [CNT_W-1:0] count,
                                      input logic             tripped,
                                      input logic             over,
                                      input logic [CNT_W-1:0] limit);
    path_t r;
    r.fire    = 1'b0;
    r.clear   = 1'b0;
    r.tripped = tripped;
    r.count   = COUNT_RST;
    if (over) begin
      if (count == limit) begin
        r.fire    = 1'b1;
        r.tripped = 1'b1;
      end else begin
        r.count = count + CNT_W'(1);
      end
    end else begin
      r.clear   = tripped;
      r.tripped = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: sv/rail_power_overload_guard.sv
// Top level of the rail power overload guard.
// Usage:
//   Input channel: one beat per telemetry sample (three rails of mV and mA plus
//   supply_mode), taken when in_valid is high and in_stall is low.
//   Output channel: one beat per sample with total_watts, reading_failed and
//   the shutdown and clear request counts, taken when out_valid is high and
//   out_stall is low. Results leave in sample order.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register;
//   only write while no sample is in flight.
//   Pipeline: the four-stage power pipeline (two reciprocal multiplies and the
//   rail product, then classification) feeds the queue and the result register.
//   Throughput: one sample per cycle while out_stall is low; the counters and
//   trip flags update in the back end as each beat leaves the queue.
//   Output stall: the four-entry queue and the front pipeline fill up, then
//   in_stall rises.
//   Reset: rst (synchronous) empties the pipeline and queue, sets counters to
//   one, clears trip flags and restores the default register values.
module rail_power_overload_guard #(
  parameter int QueueDepth = rpog_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rpog_pkg::MV_W-1:0]         slot_millivolts,
  input  logic [rpog_pkg::MA_W-1:0]         slot_milliamps,
  input  logic [rpog_pkg::MV_W-1:0]         aux_four_millivolts,
  input  logic [rpog_pkg::MA_W-1:0]         aux_four_milliamps,
  input  logic [rpog_pkg::MV_W-1:0]         aux_three_millivolts,
  input  logic [rpog_pkg::MA_W-1:0]         aux_three_milliamps,
  input  logic [rpog_pkg::MODE_W-1:0]       supply_mode,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rpog_pkg::TOTAL_W-1:0]      total_watts,
  output logic                              reading_failed,
  output logic [1:0]                        shutdown_requests,
  output logic [1:0]                        clear_requests,
  input  logic                              cfg_write,
  input  logic [rpog_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rpog_pkg::CFG_W-1:0]        cfg_data
);
  import rpog_pkg::*;

  limits_t          limits;
  logic [CNT_W-1:0] persist_limit;

  logic [RAILS-1:0][MV_W-1:0] rail_mv;
  logic [RAILS-1:0][MA_W-1:0] rail_ma;

  logic   push, pop, q_full, q_empty;
  class_t push_data, head;

  always_comb begin
    rail_mv[RAIL_SLOT] = slot_millivolts;
    rail_mv[RAIL_AUX4] = aux_four_millivolts;
    rail_mv[RAIL_AUX3] = aux_three_millivolts;
    rail_ma[RAIL_SLOT] = slot_milliamps;
    rail_ma[RAIL_AUX4] = aux_four_milliamps;
    rail_ma[RAIL_AUX3] = aux_three_milliamps;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.pex_limit  <= PEX_LIMIT_RST;
      limits.aux4_limit <= AUX4_LIMIT_RST;
      limits.aux3_limit <= AUX3_LIMIT_RST;
      limits.full_mode  <= FULL_MODE_RST;
      persist_limit     <= PERSIST_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PEX_LIMIT:  limits.pex_limit  <= cfg_data[WATT_W-1:0];
        CFG_AUX4_LIMIT: limits.aux4_limit <= cfg_data[WATT_W-1:0];
        CFG_AUX3_LIMIT: limits.aux3_limit <= cfg_data[WATT_W-1:0];
        CFG_FULL_MODE:  limits.full_mode  <= cfg_data[MODE_W-1:0];
        CFG_PERSIST:    persist_limit     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  rpog_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rail_mv   (rail_mv),
    .rail_ma   (rail_ma),
    .mode      (supply_mode),
    .limits    (limits),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  rpog_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  rpog_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (q_empty),
    .head              (head),
    .pop               (pop),
    .persist_limit     (persist_limit),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .total_watts       (total_watts),
    .reading_failed    (reading_failed),
    .shutdown_requests (shutdown_requests),
    .clear_requests    (clear_requests)
  );

endmodule

FILE: sv/rpog_front.sv
// Front end: rail power pipeline and overload classification.
module rpog_front (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic [rpog_pkg::RAILS-1:0][rpog_pkg::MV_W-1:0] rail_mv,
  input  logic [rpog_pkg::RAILS-1:0][rpog_pkg::MA_W-1:0] rail_ma,
  input  logic [rpog_pkg::MODE_W-1:0]                   mode,
  input  rpog_pkg::limits_t                             limits,
  input  logic                                          q_full,
  output logic                                          push,
  output rpog_pkg::class_t                              push_data
);
  import rpog_pkg::*;

  logic advance;
  logic s1_valid, s2_valid, s3_valid, s4_valid;

  logic [RAILS-1:0][VOLT_W-1:0] s1_volts;
  logic [RAILS-1:0][MA_W-1:0]   s1_ma;
  logic [RAILS-1:0][PROD_W-1:0] s2_prod;
  logic [RAILS-1:0][WATT_W-1:0] s3_watts;
  logic [MODE_W-1:0]            s1_mode, s2_mode, s3_mode;
  class_t                       s4_class;

  logic [RAILS-1:0][32:0] volt_mul;
  logic [RAILS-1:0][46:0] watt_mul;
  class_t                 cls;
  logic                   full;

  assign advance  = !s4_valid || !q_full;
  assign in_stall = !advance;
  assign push      = s4_valid && !q_full;
  assign push_data = s4_class;

  always_comb begin
    for (int r = 0; r < RAILS; r++) begin
      volt_mul[r] = 33'(rail_mv[r]) * 33'(VOLT_RECIP);
      watt_mul[r] = 47'(s2_prod[r]) * 47'(WATT_RECIP);
    end
  end

  always_comb begin
    full         = (s3_mode == limits.full_mode);
    cls.total    = TOTAL_W'(s3_watts[RAIL_SLOT]) + TOTAL_W'(s3_watts[RAIL_AUX4])
                 + TOTAL_W'(s3_watts[RAIL_AUX3]);
    cls.failed   = (cls.total == '0);
    cls.pex_over = (s3_watts[RAIL_SLOT] >= limits.pex_limit);
    cls.aux_over = (s3_watts[RAIL_AUX4] >= limits.aux4_limit)
                 || (full && (s3_watts[RAIL_AUX3] >= limits.aux3_limit));
    cls.full     = full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < RAILS; r++) begin
        s1_volts[r] <= volt_mul[r][VOLT_SHIFT +: VOLT_W];
        s1_ma[r]    <= rail_ma[r];
        s2_prod[r]  <= PROD_W'(s1_volts[r]) * PROD_W'(s1_ma[r]);
        s3_watts[r] <= watt_mul[r][WATT_SHIFT +: WATT_W];
      end
      s1_mode  <= mode;
      s2_mode  <= s1_mode;
      s3_mode  <= s2_mode;
      s4_class <= cls;
    end
  end

endmodule

FILE: sv/rpog_queue.sv
// Short queue of classified beats between front and back.
module rpog_queue #(
  parameter int Depth = rpog_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rpog_pkg::class_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output rpog_pkg::class_t head
);
  import rpog_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  class_t            slots [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: sv/rpog_back.sv
// Back end: persistence counters, trip flags and the result register.
module rpog_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  rpog_pkg::class_t              head,
  output logic                          pop,
  input  logic [rpog_pkg::CNT_W-1:0]    persist_limit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rpog_pkg::TOTAL_W-1:0]  total_watts,
  output logic                          reading_failed,
  output logic [1:0]                    shutdown_requests,
  output logic [1:0]                    clear_requests
);
  import rpog_pkg::*;

  logic [CNT_W-1:0] slot_cnt, dual_cnt, single_cnt;
  logic             slot_trip, dual_trip, single_trip;
  path_t            slot_nx, aux_nx;

  assign pop = !q_empty && (!out_valid || !out_stall);

  always_comb begin
    slot_nx = path_step(slot_cnt, slot_trip, head.pex_over, persist_limit);
    aux_nx  = head.full ? path_step(dual_cnt, dual_trip, head.aux_over, persist_limit)
                        : path_step(single_cnt, single_trip, head.aux_over, persist_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_cnt    <= COUNT_RST;
      dual_cnt    <= COUNT_RST;
      single_cnt  <= COUNT_RST;
      slot_trip   <= 1'b0;
      dual_trip   <= 1'b0;
      single_trip <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        slot_cnt  <= slot_nx.count;
        slot_trip <= slot_nx.tripped;
        if (head.full) begin
          dual_cnt  <= aux_nx.count;
          dual_trip <= aux_nx.tripped;
        end else begin
          single_cnt  <= aux_nx.count;
          single_trip <= aux_nx.tripped;
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      total_watts       <= head.total;
      reading_failed    <= head.failed;
      shutdown_requests <= {1'b0, slot_nx.fire} + {1'b0, aux_nx.fire};
      clear_requests    <= {1'b0, slot_nx.clear} + {1'b0, aux_nx.clear};
    end
  end

endmodule

FILE: sv/rpog_checker.sv
// Port-level checker for the overload guard and its bind.
`include "rail_power_overload_guard_macros.svh"

module rpog_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [rpog_pkg::TOTAL_W-1:0]     total_watts,
  input logic                             reading_failed,
  input logic [1:0]                       shutdown_requests,
  input logic [1:0]                       clear_requests
);

  `RPOG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(total_watts) && $stable(shutdown_requests) && $stable(clear_requests))
  `RPOG_ASSERT_NOW(a_fail_flag, out_valid, reading_failed == (total_watts == '0))
  `RPOG_ASSERT_NOW(a_req_range, out_valid, (shutdown_requests != 2'd3) && (clear_requests != 2'd3))
  `RPOG_ASSERT_NOW(a_total_range, out_valid, total_watts <= 14'd12777)

endmodule

bind rail_power_overload_guard rpog_checker u_rpog_checker (.*);

FILE: bench/rail_power_overload_guard_test.sv
// Self-checking bench for rail_power_overload_guard: predicted power, status and trip requests.
module rail_power_overload_guard_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 720;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int MAX_RAIL_WATTS = 4259;
  localparam int CFG_W = rpog_pkg::CFG_W;

  typedef struct packed {
    logic [rpog_pkg::MV_W-1:0]   slot_mv;
    logic [rpog_pkg::MA_W-1:0]   slot_ma;
    logic [rpog_pkg::MV_W-1:0]   a4_mv;
    logic [rpog_pkg::MA_W-1:0]   a4_ma;
    logic [rpog_pkg::MV_W-1:0]   a3_mv;
    logic [rpog_pkg::MA_W-1:0]   a3_ma;
    logic [rpog_pkg::MODE_W-1:0] mode;
  } sample_t;

  typedef struct packed {
    logic [rpog_pkg::TOTAL_W-1:0] total;
    logic                         failed;
    logic [1:0]                   shut;
    logic [1:0]                   clr;
  } guard_result_t;

  class guard_scoreboard;
    logic [rpog_pkg::WATT_W-1:0] pex_limit, aux4_limit, aux3_limit;
    logic [rpog_pkg::MODE_W-1:0] full_code;
    logic [rpog_pkg::CNT_W-1:0]  persist_limit, slot_count, dual_count, single_count;
    bit                          slot_trip, dual_trip, single_trip;
    guard_result_t               expected_q[$];
    int                          mismatches;

    function new();
      pex_limit     = rpog_pkg::PEX_LIMIT_RST;
      aux4_limit    = rpog_pkg::AUX4_LIMIT_RST;
      aux3_limit    = rpog_pkg::AUX3_LIMIT_RST;
      full_code     = rpog_pkg::FULL_MODE_RST;
      persist_limit = rpog_pkg::PERSIST_RST;
      slot_count    = rpog_pkg::COUNT_RST;
      dual_count    = rpog_pkg::COUNT_RST;
      single_count  = rpog_pkg::COUNT_RST;
      slot_trip     = 1'b0;
      dual_trip     = 1'b0;
      single_trip   = 1'b0;
      mismatches    = 0;
    endfunction

    function void set_reg(rpog_pkg::cfg_index_t idx, logic [rpog_pkg::CFG_W-1:0] data);
      case (idx)
        rpog_pkg::CFG_PEX_LIMIT:  pex_limit = data;
        rpog_pkg::CFG_AUX4_LIMIT: aux4_limit = data;
        rpog_pkg::CFG_AUX3_LIMIT: aux3_limit = data;
        rpog_pkg::CFG_FULL_MODE:  full_code = data[rpog_pkg::MODE_W-1:0];
        rpog_pkg::CFG_PERSIST:    persist_limit = data[rpog_pkg::CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned rail_watts(logic [15:0] mv, logic [15:0] ma);
      int unsigned volts;
      volts = mv / 1000;
      return (volts * ma) / 1000;
    endfunction

    // count wraps at 8 bits, so a limit below the running count fires after the wrap
    function bit overload_step(inout logic [7:0] count, inout bit tripped);
      bit fired;
      fired = 1'b0;
      if (count == persist_limit) begin
        fired   = 1'b1;
        tripped = 1'b1;
        count   = 8'd0;
      end
      count = count + 8'd1;
      return fired;
    endfunction

    function bit release_step(inout logic [7:0] count, inout bit tripped);
      bit cleared;
      cleared = tripped;
      tripped = 1'b0;
      count   = rpog_pkg::COUNT_RST;
      return cleared;
    endfunction

    function void note_sample(sample_t s);
      int unsigned   pex, a4, a3, total, shut, clr;
      bit            full, pex_over, aux_over;
      guard_result_t r;
      pex   = rail_watts(s.slot_mv, s.slot_ma);
      a4    = rail_watts(s.a4_mv, s.a4_ma);
      a3    = rail_watts(s.a3_mv, s.a3_ma);
      total = pex + a4 + a3;
      full  = (s.mode == full_code);
      pex_over = (pex >= pex_limit);
      aux_over = full ? (a4 >= aux4_limit || a3 >= aux3_limit) : (a4 >= aux4_limit);
      shut = 0;
      clr  = 0;
      if (pex_over) shut += overload_step(slot_count, slot_trip);
      if (aux_over) begin
        if (full) shut += overload_step(dual_count, dual_trip);
        else shut += overload_step(single_count, single_trip);
      end
      if (!pex_over) clr += release_step(slot_count, slot_trip);
      if (!aux_over) begin
        if (full) clr += release_step(dual_count, dual_trip);
        else clr += release_step(single_count, single_trip);
      end
      r.total  = total[rpog_pkg::TOTAL_W-1:0];
      r.failed = (total == 0);
      r.shut   = shut[1:0];
      r.clr    = clr[1:0];
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_result(guard_result_t got);
      guard_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with none expected", got.total, -1);
        return;
      end
      want = expected_q.pop_front();
      if (got.total != want.total) report_mismatch("total_watts", got.total, want.total);
      if (got.failed != want.failed) report_mismatch("reading_failed", got.failed, want.failed);
      if (got.shut != want.shut) report_mismatch("shutdown_requests", got.shut, want.shut);
      if (got.clr != want.clr) report_mismatch("clear_requests", got.clr, want.clr);
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  sample_t                      offered = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [rpog_pkg::TOTAL_W-1:0] total_watts;
  logic                         reading_failed;
  logic [1:0]                   shutdown_requests;
  logic [1:0]                   clear_requests;
  logic                         cfg_write = 1'b0;
  rpog_pkg::cfg_index_t         cfg_index = rpog_pkg::CFG_PEX_LIMIT;
  logic [rpog_pkg::CFG_W-1:0]   cfg_data = '0;

  guard_scoreboard sb;
  bit              no_gaps = 1'b0;
  bit              hold_off_request = 1'b0;
  int              random_sent = 0;
  int              cycles = 0;

  rail_power_overload_guard u_dut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .slot_millivolts      (offered.slot_mv),
    .slot_milliamps       (offered.slot_ma),
    .aux_four_millivolts  (offered.a4_mv),
    .aux_four_milliamps   (offered.a4_ma),
    .aux_three_millivolts (offered.a3_mv),
    .aux_three_milliamps  (offered.a3_ma),
    .supply_mode          (offered.mode),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .total_watts          (total_watts),
    .reading_failed       (reading_failed),
    .shutdown_requests    (shutdown_requests),
    .clear_requests       (clear_requests),
    .cfg_write            (cfg_write),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // beat monitor
  always @(posedge clk) begin
    guard_result_t seen;
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_sample(offered);
      if (out_valid && !out_stall) begin
        seen.total  = total_watts;
        seen.failed = reading_failed;
        seen.shut   = shutdown_requests;
        seen.clr    = clear_requests;
        sb.check_result(seen);
      end
    end
  end

  // result side: random stall per beat, one long hold-off on request
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 6);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  task send_sample(sample_t s);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    offered  <= s;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task write_reg(rpog_pkg::cfg_index_t idx, logic [rpog_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task write_all(int pex, int a4, int a3, int code, int persist);
    write_reg(rpog_pkg::CFG_PEX_LIMIT, CFG_W'(pex));
    write_reg(rpog_pkg::CFG_AUX4_LIMIT, CFG_W'(a4));
    write_reg(rpog_pkg::CFG_AUX3_LIMIT, CFG_W'(a3));
    write_reg(rpog_pkg::CFG_FULL_MODE, CFG_W'(code));
    write_reg(rpog_pkg::CFG_PERSIST, CFG_W'(persist));
  endtask

  // mV/mA pair giving exactly w watts
  function automatic logic [31:0] rail_at(int unsigned w);
    int unsigned vmin, v, ma, mv;
    if (w == 0) return {16'($urandom_range(0, 999)), 16'($urandom)};
    vmin = (w * 1000 + 65534) / 65535;
    if (vmin < 1) vmin = 1;
    v  = $urandom_range(vmin, 65);
    ma = (w * 1000 + v - 1) / v;
    mv = v * 1000 + $urandom_range(0, (v == 65) ? 535 : 999);
    return {16'(mv), 16'(ma)};
  endfunction

  function automatic logic [31:0] rail_near(int unsigned lim, bit over);
    int unsigned top, w;
    if (over && lim <= MAX_RAIL_WATTS) begin
      top = MAX_RAIL_WATTS - lim;
      w = lim + $urandom_range(0, (top < 20) ? top : 20);
    end else if (lim == 0) begin
      w = $urandom_range(0, MAX_RAIL_WATTS);
    end else begin
      top = (lim - 1 > MAX_RAIL_WATTS) ? MAX_RAIL_WATTS : lim - 1;
      w = top - $urandom_range(0, (top < 20) ? top : 20);
    end
    return rail_at(w);
  endfunction

  function automatic sample_t watts_sample(int unsigned ws, int unsigned w4, int unsigned w3,
                                           logic [7:0] m);
    sample_t s;
    {s.slot_mv, s.slot_ma} = rail_at(ws);
    {s.a4_mv, s.a4_ma}     = rail_at(w4);
    {s.a3_mv, s.a3_ma}     = rail_at(w3);
    s.mode = m;
    return s;
  endfunction

  function automatic sample_t fixed_sample(logic [15:0] mv, logic [15:0] ma, logic [7:0] m);
    return '{mv, ma, mv, ma, mv, ma, m};
  endfunction

  function automatic sample_t make_sample(bit so, bit a4o, bit a3o, logic [7:0] m);
    sample_t s;
    {s.slot_mv, s.slot_ma} = rail_near(sb.pex_limit, so);
    {s.a4_mv, s.a4_ma}     = rail_near(sb.aux4_limit, a4o);
    {s.a3_mv, s.a3_ma}     = rail_near(sb.aux3_limit, a3o);
    s.mode = m;
    return s;
  endfunction

  function automatic sample_t noise_sample();
    return '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 16'($urandom), 8'($urandom)};
  endfunction

  function automatic logic [7:0] pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return sb.full_code;
    if (r < 9) return sb.full_code ^ 8'($urandom_range(1, 255));
    return 8'($urandom);
  endfunction

  function automatic int pick_limit();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 400);
    if (r < 17) return $urandom_range(0, MAX_RAIL_WATTS);
    case ($urandom_range(0, 2))
      0: return 0;
      1: return MAX_RAIL_WATTS;
      default: return 8191;
    endcase
  endfunction

  function automatic int pick_persist();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(2, 12);
    if (r < 18) return $urandom_range(2, 255);
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 1;
      default: return 255;
    endcase
  endfunction

  // runs of steady overload pattern per path, with some flipped and noise beats
  task run_random_phase(int n);
    int         seg, lim;
    bit         so, a4o, a3o;
    logic [7:0] m;
    while (n > 0) begin
      lim = sb.persist_limit + 3;
      seg = $urandom_range(1, (lim > 20) ? 20 : lim);
      so  = $urandom_range(0, 1);
      a4o = $urandom_range(0, 1);
      a3o = $urandom_range(0, 1);
      m   = pick_mode();
      repeat (seg) begin
        if ($urandom_range(0, 99) < 15) send_sample(noise_sample());
        else if ($urandom_range(0, 9) == 0) send_sample(make_sample(!so, a4o, !a3o, m));
        else send_sample(make_sample(so, a4o, a3o, m));
        random_sent++;
        n--;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, exact thresholds, both aux paths at reset settings
    send_sample(fixed_sample(16'h0000, 16'h0000, 8'h00));
    send_sample(fixed_sample(16'hFFFF, 16'hFFFF, 8'hFF));
    send_sample(fixed_sample(16'hAAAA, 16'hAAAA, 8'hAA));
    send_sample(fixed_sample(16'h5555, 16'h5555, 8'h55));
    send_sample(fixed_sample(16'd999, 16'hFFFF, 8'h00));
    send_sample(fixed_sample(16'hFFFF, 16'h0000, 8'h00));
    send_sample(watts_sample(74, 149, 74, 8'h00));
    repeat (11) send_sample(watts_sample(75, 149, 75, 8'h00));
    send_sample(watts_sample(74, 149, 74, 8'h00));
    repeat (3) send_sample(watts_sample(0, 150, 0, 8'h05));
    // aux3 overload ignored outside full mode
    send_sample(watts_sample(0, 0, 200, 8'h05));
    drain();

    // limit of one fires on every overloaded beat
    write_reg(rpog_pkg::CFG_PERSIST, CFG_W'(1));
    repeat (6) send_sample(make_sample(1'b1, $urandom_range(0, 1), $urandom_range(0, 1),
                                       pick_mode()));
    drain();

    // limit of zero fires only at the counter wrap
    write_reg(rpog_pkg::CFG_PERSIST, CFG_W'(0));
    repeat (270) send_sample(make_sample(1'b1, $urandom_range(0, 1), 1'b0, pick_mode()));
    drain();

    // limit lowered under a running count
    write_reg(rpog_pkg::CFG_PERSIST, CFG_W'(200));
    repeat (30) send_sample(make_sample(1'b1, 1'b1, 1'b1, sb.full_code));
    drain();
    write_reg(rpog_pkg::CFG_PERSIST, CFG_W'(5));
    repeat (260) send_sample(make_sample(1'b1, 1'b1, 1'b1, sb.full_code));
    drain();

    // thresholds at the maximum rail power, above it, and at zero
    write_all(MAX_RAIL_WATTS, MAX_RAIL_WATTS, MAX_RAIL_WATTS, 255, 2);
    repeat (4) send_sample(fixed_sample(16'hFFFF, 16'hFFFF, 8'hFF));
    repeat (3) send_sample(fixed_sample(16'hFFFF, 16'hFFFF, 8'h00));
    drain();
    write_all(8191, 8191, 8191, 255, 2);
    repeat (4) send_sample(fixed_sample(16'hFFFF, 16'hFFFF, 8'hFF));
    drain();
    write_all(0, 0, 0, 0, 2);
    repeat (4) send_sample(fixed_sample(16'h0000, 16'h0000, 8'h00));
    send_sample(fixed_sample(16'h0000, 16'h0000, 8'h01));
    drain();

    // long hold-off on results while beats keep coming
    write_all(75, 150, 75, 3, 3);
    no_gaps = 1'b1;
    hold_off_request = 1'b1;
    run_random_phase(40);
    no_gaps = 1'b0;

    while (random_sent < RANDOM_ITEMS) begin
      drain();
      write_all(pick_limit(), pick_limit(), pick_limit(), $urandom_range(0, 255), pick_persist());
      no_gaps = ($urandom_range(0, 4) == 0);
      run_random_phase($urandom_range(40, 120));
    end
    no_gaps = 1'b0;
    drain();
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: rail_power_overload_guard.f
+incdir+sv
sv/rpog_pkg.sv
sv/rpog_front.sv
sv/rpog_queue.sv
sv/rpog_back.sv
sv/rail_power_overload_guard.sv
sv/rpog_checker.sv
bench/rail_power_overload_guard_test.sv
